[src/ptp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and constants for the perspective point transform.
// ----------------------------------------------------------------------------
package ptp_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COORDS    = 3;
  localparam int DIV_NUM_W     = 64;
  localparam int DIV_STEPS     = 16;

  localparam logic [REG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_C01 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_C23 = 3'd7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic [63:0] data;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = 66'sh0_7FFF_FFFF;
    mn = -66'sh0_8000_0000;
    if (v > mx) return 32'sh7FFF_FFFF;
    if (v < mn) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic is_sat32(input logic signed [65:0] v);
    return (v > 66'sh0_7FFF_FFFF) || (v < -66'sh0_8000_0000);
  endfunction
endpackage

[src/ptp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_if
// Valid/ready stream channel with a generic payload.
// ----------------------------------------------------------------------------
interface ptp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/ptp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_lane
// One matrix row: three products, truncated, plus the offset, saturated.
// Two pipeline stages; advance on en.
// ----------------------------------------------------------------------------
module ptp_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [63:0]        cols01,
  input  logic [63:0]        cols23,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic signed [31:0] sum,
  output logic               sum_sat
);
  import ptp_pkg::*;

  logic signed [63:0] prod0, prod1, prod2;
  logic signed [31:0] offs;
  logic signed [65:0] acc;

  always_ff @(posedge clk) begin
    if (en) begin
      prod0 <= $signed(cols01[31:0]) * px;
      prod1 <= $signed(cols01[63:32]) * py;
      prod2 <= $signed(cols23[31:0]) * pz;
      offs  <= $signed(cols23[63:32]);
    end
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    acc = 66'(prod0 >>> FRAC_BITS) + 66'(prod1 >>> FRAC_BITS)
        + 66'(prod2 >>> FRAC_BITS) + 66'(offs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum     <= sat32(acc);
      sum_sat <= is_sat32(acc);
    end
  end
endmodule

[src/ptp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_div
// Pipelined signed divide (num << FRAC_BITS) / den, truncated toward zero.
// Restoring radix-2, DIV_NUM_W/DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module ptp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo,
  output logic               quo_sat
);
  import ptp_pkg::*;

  localparam int BPS = DIV_NUM_W / DIV_STEPS;

  logic [DIV_NUM_W-1:0] n_q   [DIV_STEPS+1];
  logic [DIV_NUM_W-1:0] r_q   [DIV_STEPS+1];
  logic [31:0]          d_q   [DIV_STEPS+1];
  logic                 neg_q [DIV_STEPS+1];

  logic [DIV_NUM_W-1:0] n_abs;
  logic [31:0]          d_abs;
  logic signed [63:0]   num_ext;

  always_comb begin
    num_ext = 64'(num) <<< FRAC_BITS;
    n_abs   = num_ext[63] ? 64'(-num_ext) : 64'(num_ext);
    d_abs   = den[31] ? 32'(-den) : 32'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0]   <= n_abs;
      r_q[0]   <= '0;
      d_q[0]   <= d_abs;
      neg_q[0] <= num_ext[63] ^ den[31];
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    logic [DIV_NUM_W-1:0] n_w, r_w;
    logic [DIV_NUM_W:0]   t;
    always_comb begin
      n_w = n_q[s];
      r_w = r_q[s];
      for (int b = 0; b < BPS; b++) begin
        t   = {r_w, n_w[DIV_NUM_W-1]};
        n_w = {n_w[DIV_NUM_W-2:0], 1'b0};
        if (t >= (DIV_NUM_W+1)'(d_q[s])) begin
          r_w = DIV_NUM_W'(t - (DIV_NUM_W+1)'(d_q[s]));
          n_w[0] = 1'b1;
        end else begin
          r_w = t[DIV_NUM_W-1:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[s+1]   <= n_w;
        r_q[s+1]   <= r_w;
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  logic [65:0]        mag;
  logic signed [65:0] sq;
  always_comb begin
    mag = {2'b00, n_q[DIV_STEPS]};
    sq  = neg_q[DIV_STEPS] ? -$signed(mag) : $signed(mag);
    quo     = sat32(sq);
    quo_sat = is_sat32(sq);
  end
endmodule

[src/point_transform_perspective_top.sv]
`timescale 1ns / 1ps
// Path: the row-lane stages, then the divider's input register and quotient
// stages, then the output register; bypass values travel alongside the divider.
// Throughput: one point per cycle while the output is not stalled, set by the fully pipelined lanes and divider.
// The whole pipeline holds when the output register is full and not taken.
// Reset: synchronous; clears valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
// point_transform_perspective_top
// 4x4 homogeneous transform with perspective divide, Q fixed point.
// ----------------------------------------------------------------------------
module point_transform_perspective_top #(
  parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  ptp_if.sink   in_ch,
  ptp_if.sink   cfg_ch,
  ptp_if.source out_ch
);
  import ptp_pkg::*;

  localparam int LAT = 2 + DIV_STEPS + 2;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [63:0] mat [NUM_REGS];
  logic        en;
  logic [LAT-1:0] vld;
  point_t      pt;

  assign pt = in_ch.data;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en && !rst;
  assign cfg_ch.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[REG_ROW0_C01] <= 64'(ONE);
      mat[REG_ROW0_C23] <= '0;
      mat[REG_ROW1_C01] <= 64'(ONE) << 32;
      mat[REG_ROW1_C23] <= '0;
      mat[REG_ROW2_C01] <= '0;
      mat[REG_ROW2_C23] <= 64'(ONE);
      mat[REG_ROW3_C01] <= '0;
      mat[REG_ROW3_C23] <= 64'(ONE) << 32;
    end else if (cfg_ch.valid && cfg_ch.data.idx < 6'(NUM_REGS)) begin
      mat[cfg_ch.data.idx[REG_IDX_W-1:0]] <= cfg_ch.data.data;
    end
  end

  logic signed [31:0] s   [NUM_ROWS];
  logic               ss  [NUM_ROWS];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    ptp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .cols01(mat[2*r]), .cols23(mat[2*r+1]),
      .px(pt.x), .py(pt.y), .pz(pt.z), .sum(s[r]), .sum_sat(ss[r]));
  end

  logic signed [31:0] q  [NUM_COORDS];
  logic               qs [NUM_COORDS];
  for (genvar c = 0; c < NUM_COORDS; c++) begin : g_div
    ptp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(en), .num(s[c]), .den(s[3]), .quo(q[c]), .quo_sat(qs[c]));
  end

  // carry bypass values alongside the divider
  logic signed [31:0] sd  [DIV_STEPS+1][NUM_COORDS];
  logic               wz_d   [DIV_STEPS+1];
  logic               one_d  [DIV_STEPS+1];
  logic               rsat_d [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_COORDS; c++) sd[0][c] <= s[c];
      wz_d[0]   <= s[3] == 32'sd0;
      one_d[0]  <= s[3] == ONE;
      rsat_d[0] <= ss[0] | ss[1] | ss[2] | ss[3];
      for (int k = 1; k <= DIV_STEPS; k++) begin
        sd[k]     <= sd[k-1];
        wz_d[k]   <= wz_d[k-1];
        one_d[k]  <= one_d[k-1];
        rsat_d[k] <= rsat_d[k-1];
      end
    end
  end

  result_t res_next;
  always_comb begin
    res_next.w_zero = wz_d[DIV_STEPS];
    priority if (wz_d[DIV_STEPS]) begin
      res_next.out_x = '0; res_next.out_y = '0; res_next.out_z = '0;
      res_next.saturated = rsat_d[DIV_STEPS];
    end else if (one_d[DIV_STEPS]) begin
      res_next.out_x = sd[DIV_STEPS][0];
      res_next.out_y = sd[DIV_STEPS][1];
      res_next.out_z = sd[DIV_STEPS][2];
      res_next.saturated = rsat_d[DIV_STEPS];
    end else begin
      res_next.out_x = q[0]; res_next.out_y = q[1]; res_next.out_z = q[2];
      res_next.saturated = rsat_d[DIV_STEPS] | qs[0] | qs[1] | qs[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_ch.data <= res_next;
  end

  assign out_ch.valid = vld[LAT-1];
endmodule
